// ===== rtl/bcd_pkg.sv =====
package bcd_pkg;

   // field widths
   localparam int PIN_COUNT  = 8;
   localparam int NOW_WIDTH  = 32;
   localparam int CODE_WIDTH = 9;
   localparam int CNT_WIDTH  = 4;
   localparam int MS_WIDTH   = 16;
   localparam int CSR_WIDTH  = 16;
   localparam int IDX_WIDTH  = 2;

   // button limit and default time width
   localparam int MAX_BUTTONS       = 8;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam logic [CNT_WIDTH-1:0] BTN_LIMIT =
      CNT_WIDTH'((MAX_BUTTONS < PIN_COUNT) ? MAX_BUTTONS : PIN_COUNT);

   // register indexes
   localparam logic [IDX_WIDTH-1:0] REG_ACTIVE_HIGH   = 2'd0;
   localparam logic [IDX_WIDTH-1:0] REG_BUTTON_COUNT  = 2'd1;
   localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE_MS   = 2'd2;
   localparam logic [IDX_WIDTH-1:0] REG_LONG_PRESS_MS = 2'd3;

   // register reset values
   localparam logic                 ACTIVE_HIGH_RESET   = 1'b0;
   localparam logic [CNT_WIDTH-1:0] BUTTON_COUNT_RESET  = 4'd8;
   localparam logic [MS_WIDTH-1:0]  DEBOUNCE_MS_RESET   = 16'd50;
   localparam logic [MS_WIDTH-1:0]  LONG_PRESS_MS_RESET = 16'd950;

   typedef struct packed {
      logic                 active_high;
      logic [CNT_WIDTH-1:0] button_count;
      logic [MS_WIDTH-1:0]  debounce_ms;
      logic [MS_WIDTH-1:0]  long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [PIN_COUNT-1:0] pin_levels;
      logic [NOW_WIDTH-1:0] now_ms;
   } stage_type;

endpackage

// ===== rtl/bcd_req_if.sv =====
interface bcd_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcd_pkg::PIN_COUNT-1:0] pin_levels;
   logic [bcd_pkg::NOW_WIDTH-1:0] now_ms;

   modport source (output valid, output pin_levels, output now_ms, input ready);
   modport sink (input valid, input pin_levels, input now_ms, output ready);
endinterface

// ===== rtl/bcd_rsp_if.sv =====
interface bcd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bcd_pkg::CODE_WIDTH-1:0] press_code;

   modport source (output valid, output press_code, input ready);
   modport sink (input valid, input press_code, output ready);
endinterface

// ===== rtl/bcd_csr.sv =====
module bcd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [bcd_pkg::IDX_WIDTH-1:0] csr_index,
   input  logic [bcd_pkg::CSR_WIDTH-1:0] csr_wdata,
   output bcd_pkg::cfg_type              cfg
);

   bcd_pkg::cfg_type cfg_ff;
   bcd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            bcd_pkg::REG_ACTIVE_HIGH:   cfg_in.active_high = csr_wdata[0];
            bcd_pkg::REG_BUTTON_COUNT:
               cfg_in.button_count = csr_wdata[bcd_pkg::CNT_WIDTH-1:0];
            bcd_pkg::REG_DEBOUNCE_MS:
               cfg_in.debounce_ms = csr_wdata[bcd_pkg::MS_WIDTH-1:0];
            bcd_pkg::REG_LONG_PRESS_MS:
               cfg_in.long_press_ms = csr_wdata[bcd_pkg::MS_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high   <= bcd_pkg::ACTIVE_HIGH_RESET;
         cfg_ff.button_count  <= bcd_pkg::BUTTON_COUNT_RESET;
         cfg_ff.debounce_ms   <= bcd_pkg::DEBOUNCE_MS_RESET;
         cfg_ff.long_press_ms <= bcd_pkg::LONG_PRESS_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bcd_input_stage.sv =====
module bcd_input_stage (
   input  logic                clock,
   input  logic                reset,
   bcd_req_if.sink             req,
   input  logic                take,
   output bcd_pkg::stage_type  stage
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [bcd_pkg::PIN_COUNT-1:0] pins_ff;
   logic [bcd_pkg::NOW_WIDTH-1:0] now_ff;
   logic                          xfer;

   // stage frees up when its poll moves into the core this cycle
   assign req.ready = !valid_ff || take;
   assign xfer      = req.valid && req.ready;

   always_comb begin
      if (xfer) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         pins_ff <= req.pin_levels;
         now_ff  <= req.now_ms;
      end
   end

   assign stage.valid      = valid_ff;
   assign stage.pin_levels = pins_ff;
   assign stage.now_ms     = now_ff;

endmodule

// ===== rtl/bcd_core.sv =====
module bcd_core #(
   parameter int TIME_BITS = bcd_pkg::TIME_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  bcd_pkg::cfg_type   cfg,
   input  bcd_pkg::stage_type stage,
   output logic               take,
   bcd_rsp_if.source          rsp
);

   localparam int PC = bcd_pkg::PIN_COUNT;
   localparam int CW = bcd_pkg::CNT_WIDTH;

   logic                 open_ff, open_in;
   logic [TIME_BITS-1:0] press_dl_ff, press_dl_in;
   logic [TIME_BITS-1:0] release_dl_ff, release_dl_in;
   logic [PC-1:0]        held_ff, held_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [bcd_pkg::CODE_WIDTH-1:0] code_ff, code_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] deb_t;
   logic [TIME_BITS-1:0] long_dl;
   logic [PC-1:0]        level;
   logic [PC-1:0]        en_mask;
   logic [PC-1:0]        pressed;
   logic [CW-1:0]        count;
   logic                 fire;
   logic                 active;

   assign take = !rsp_valid_ff || rsp.ready;
   assign fire = stage.valid && take;

   assign now_t   = TIME_BITS'(stage.now_ms);
   assign deb_t   = TIME_BITS'(cfg.debounce_ms);
   assign long_dl = press_dl_ff + TIME_BITS'(cfg.long_press_ms);

   // polarity fix, then keep only the configured low-order buttons
   assign level = cfg.active_high ? stage.pin_levels : ~stage.pin_levels;
   assign count = (cfg.button_count > bcd_pkg::BTN_LIMIT) ? bcd_pkg::BTN_LIMIT
                                                          : cfg.button_count;
   always_comb begin
      for (int i = 0; i < PC; i++) begin
         en_mask[i] = CW'(i) < count;
      end
   end
   assign pressed = level & en_mask;

   assign active = (pressed != '0 || open_ff) && (release_dl_ff < now_t);

   always_comb begin
      open_in       = open_ff;
      press_dl_in   = press_dl_ff;
      release_dl_in = release_dl_ff;
      held_in       = held_ff;
      code_in       = '0;
      if (active) begin
         if (!open_ff) begin
            press_dl_in = now_t + deb_t;
            open_in     = 1'b1;
         end
         if (held_ff < pressed) begin
            held_in = pressed;
         end
         // a newly opened episode has pressed buttons, so release needs open_ff
         if (pressed == '0 && open_ff && press_dl_ff < now_t) begin
            code_in       = {now_t > long_dl, held_ff};
            open_in       = 1'b0;
            held_in       = '0;
            release_dl_in = now_t + deb_t;
         end
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         press_dl_ff   <= '0;
         release_dl_ff <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            open_ff       <= open_in;
            press_dl_ff   <= press_dl_in;
            release_dl_ff <= release_dl_in;
            held_ff       <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         code_ff <= code_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.press_code = code_ff;

endmodule

// ===== rtl/button_combo_debouncer_unit.sv =====
// Button debouncer with combination capture and long-press flag. Each req
// transfer is one poll (raw pin levels plus the current millisecond time) and
// yields exactly one rsp transfer: press_code is 0 when nothing happened, or
// the largest button mask seen during the press (bit 8 set for a long press)
// once all buttons are released. Throughput is one poll per clock while rsp
// is ready; a poll passes through the input register and then the core
// register, whose path is one time add and compare. While a result waits
// on rsp, the input register holds at most one more poll, then req stalls.
// Deadlines are TIME_BITS wide and wrap; compares are plain unsigned.
// Configuration registers (0 polarity, 1 button count, 2 debounce ms,
// 3 long-press ms) take effect on the next poll and should be written while
// no poll is in flight.
module button_combo_debouncer_unit #(
   parameter int TIME_BITS = bcd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   bcd_req_if.sink                       req,
   bcd_rsp_if.source                     rsp,
   input  logic                          csr_write_en,
   input  logic [bcd_pkg::IDX_WIDTH-1:0] csr_index,
   input  logic [bcd_pkg::CSR_WIDTH-1:0] csr_wdata
);

   bcd_pkg::cfg_type   cfg;
   bcd_pkg::stage_type stage;
   logic               take;

   bcd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bcd_input_stage u_input_stage (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .take  (take),
      .stage (stage)
   );

   bcd_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .stage (stage),
      .take  (take),
      .rsp   (rsp)
   );

endmodule

// ===== tb/press_code_checker.sv =====
module press_code_checker import bcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bcd_req_if                   req,
   bcd_rsp_if                   rsp,
   input  logic                 csr_write_en,
   input  logic [IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   output int                   mismatches,
   output int                   pending
);

   cfg_type                 cfg;
   logic                    episode_open;
   logic [NOW_WIDTH-1:0]    press_deadline;
   logic [NOW_WIDTH-1:0]    release_deadline;
   logic [PIN_COUNT-1:0]    held_mask;
   logic [CODE_WIDTH-1:0]   expected_codes[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // advances the debouncer state by one poll and returns its press code
   function automatic logic [CODE_WIDTH-1:0] predict_poll(
      input logic [PIN_COUNT-1:0] pins,
      input logic [NOW_WIDTH-1:0] now
   );
      logic [PIN_COUNT-1:0]  level;
      logic [CNT_WIDTH-1:0]  count;
      logic [PIN_COUNT-1:0]  pressed;
      logic [NOW_WIDTH-1:0]  long_deadline;
      logic [CODE_WIDTH-1:0] code;
      level   = cfg.active_high ? pins : ~pins;
      count   = (cfg.button_count > BTN_LIMIT) ? BTN_LIMIT : cfg.button_count;
      pressed = level & PIN_COUNT'((9'd1 << count) - 9'd1);
      code    = '0;
      if ((pressed != '0 || episode_open) && release_deadline < now) begin
         if (!episode_open) begin
            press_deadline = now + NOW_WIDTH'(cfg.debounce_ms);
            episode_open   = 1'b1;
         end
         if (held_mask < pressed) held_mask = pressed;
         if (pressed == '0 && press_deadline < now) begin
            long_deadline    = press_deadline + NOW_WIDTH'(cfg.long_press_ms);
            code             = {now > long_deadline, held_mask};
            episode_open     = 1'b0;
            held_mask        = '0;
            release_deadline = now + NOW_WIDTH'(cfg.debounce_ms);
         end
      end
      return code;
   endfunction

   always @(posedge clock) begin
      logic [CODE_WIDTH-1:0] oldest;
      if (reset) begin
         cfg.active_high   = ACTIVE_HIGH_RESET;
         cfg.button_count  = BUTTON_COUNT_RESET;
         cfg.debounce_ms   = DEBOUNCE_MS_RESET;
         cfg.long_press_ms = LONG_PRESS_MS_RESET;
         episode_open      = 1'b0;
         press_deadline    = '0;
         release_deadline  = '0;
         held_mask         = '0;
         expected_codes.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_codes.size() == 0) begin
               mismatches++;
               $error("press_code: expected none, actual %0d", rsp.press_code);
            end else begin
               oldest = expected_codes.pop_front();
               if (rsp.press_code !== oldest) begin
                  mismatches++;
                  $error("press_code: expected %0d, actual %0d", oldest, rsp.press_code);
               end
            end
         end
         if (req.valid && req.ready)
            expected_codes.push_back(predict_poll(req.pin_levels, req.now_ms));
         if (csr_write_en) begin
            case (csr_index)
               REG_ACTIVE_HIGH:   cfg.active_high   = csr_wdata[0];
               REG_BUTTON_COUNT:  cfg.button_count  = csr_wdata[CNT_WIDTH-1:0];
               REG_DEBOUNCE_MS:   cfg.debounce_ms   = csr_wdata[MS_WIDTH-1:0];
               REG_LONG_PRESS_MS: cfg.long_press_ms = csr_wdata[MS_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_codes.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   import bcd_pkg::*;

   localparam int POLL_TARGET   = 1200;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [IDX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;
   int                   mismatches;
   int                   pending;
   int                   polls_sent;
   int                   burst_left;
   logic [NOW_WIDTH-1:0] poll_time;
   cfg_type              cfg_shadow;

   bcd_req_if req_ch ();
   bcd_rsp_if rsp_ch ();

   button_combo_debouncer_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   press_code_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .pending      (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("button_combo_debouncer_unit: mismatch");
      $finish;
   end

   // result side: stall pattern switches among four random modes
   initial begin
      int rx_mode;
      int rx_left;
      rx_mode = 0;
      rx_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
         end
         rx_left--;
         case (rx_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ((rx_left % 5) < 2);
         endcase
      end
   end

   task automatic send_poll(input logic [PIN_COUNT-1:0] pins, input logic [NOW_WIDTH-1:0] stamp);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      req_ch.valid      <= 1'b1;
      req_ch.pin_levels <= pins;
      req_ch.now_ms     <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      polls_sent++;
   endtask

   // hold polls back until every outstanding press code has come out
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IDX_WIDTH-1:0] index, input logic [CSR_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      case (index)
         REG_ACTIVE_HIGH:   cfg_shadow.active_high   = data[0];
         REG_BUTTON_COUNT:  cfg_shadow.button_count  = data[CNT_WIDTH-1:0];
         REG_DEBOUNCE_MS:   cfg_shadow.debounce_ms   = data[MS_WIDTH-1:0];
         REG_LONG_PRESS_MS: cfg_shadow.long_press_ms = data[MS_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // raw pin levels for a pressed set; pins beyond the button count get noise
   function automatic logic [PIN_COUNT-1:0] pins_for(input logic [PIN_COUNT-1:0] pressed);
      logic [CNT_WIDTH-1:0] count;
      logic [PIN_COUNT-1:0] keep;
      logic [PIN_COUNT-1:0] raw;
      count = (cfg_shadow.button_count > BTN_LIMIT) ? BTN_LIMIT : cfg_shadow.button_count;
      keep  = PIN_COUNT'((9'd1 << count) - 9'd1);
      raw   = cfg_shadow.active_high ? pressed : ~pressed;
      return (raw & keep) | (PIN_COUNT'($urandom) & ~keep);
   endfunction

   // time steps cluster around the debounce and long-press boundaries
   function automatic logic [NOW_WIDTH-1:0] time_step();
      int span;
      span = int'(cfg_shadow.debounce_ms) + int'(cfg_shadow.long_press_ms);
      case ($urandom_range(0, 9))
         0:          return 0;
         1:          return 1;
         2, 3, 4, 5: return $urandom_range(0, cfg_shadow.debounce_ms / 2 + 2);
         6:          return NOW_WIDTH'(cfg_shadow.debounce_ms);
         7:          return int'(cfg_shadow.debounce_ms) + 1;
         8:          return $urandom_range(0, span + 2);
         default:    return span + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic timed_poll(input logic [PIN_COUNT-1:0] pressed);
      poll_time = poll_time + time_step();
      send_poll(pins_for(pressed), poll_time);
   endtask

   // idle polls, a held combination that grows or shifts, then release
   task automatic run_episode();
      int idle_polls;
      int hold_polls;
      int release_polls;
      idle_polls    = $urandom_range(0, 3);
      hold_polls    = $urandom_range(1, 6);
      release_polls = $urandom_range(1, 3);
      repeat (idle_polls) timed_poll('0);
      repeat (hold_polls) timed_poll(PIN_COUNT'($urandom_range(1, 255)));
      repeat (release_polls) timed_poll('0);
   endtask

   task automatic pick_config();
      if ($urandom_range(0, 1) != 0)
         write_reg(REG_ACTIVE_HIGH, CSR_WIDTH'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) != 0) begin
         case ($urandom_range(0, 5))
            0:       write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(0));
            1:       write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(15));
            2:       write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(8));
            default: write_reg(REG_BUTTON_COUNT, CSR_WIDTH'($urandom_range(0, 15)));
         endcase
      end
      if ($urandom_range(0, 1) != 0) begin
         case ($urandom_range(0, 7))
            0:       write_reg(REG_DEBOUNCE_MS, CSR_WIDTH'(0));
            1:       write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
            2:       write_reg(REG_DEBOUNCE_MS, CSR_WIDTH'(1));
            default: write_reg(REG_DEBOUNCE_MS, CSR_WIDTH'($urandom_range(0, 120)));
         endcase
      end
      if ($urandom_range(0, 1) != 0) begin
         case ($urandom_range(0, 7))
            0:       write_reg(REG_LONG_PRESS_MS, CSR_WIDTH'(0));
            1:       write_reg(REG_LONG_PRESS_MS, 16'hFFFF);
            default: write_reg(REG_LONG_PRESS_MS, CSR_WIDTH'($urandom_range(0, 600)));
         endcase
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.pin_levels = '0;
      req_ch.now_ms     = '0;
      csr_write_en      = 1'b0;
      csr_index         = REG_ACTIVE_HIGH;
      csr_wdata         = '0;
      reset             = 1'b1;
      polls_sent        = 0;
      burst_left        = 0;
      poll_time         = '0;
      cfg_shadow.active_high   = ACTIVE_HIGH_RESET;
      cfg_shadow.button_count  = BUTTON_COUNT_RESET;
      cfg_shadow.debounce_ms   = DEBOUNCE_MS_RESET;
      cfg_shadow.long_press_ms = LONG_PRESS_MS_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings, pull-up wiring
      send_poll(8'hFF, 0);
      send_poll(8'hFE, 10);
      send_poll(8'hFC, 30);
      // release exactly at the press deadline, then one past it
      send_poll(8'hFF, 60);
      send_poll(8'hFF, 61);
      send_poll(8'h00, 111);
      send_poll(8'h00, 112);
      send_poll(8'h7F, 1200);
      send_poll(8'hFF, 1300);
      // deadline wraps past zero
      send_poll(8'hFE, 32'hFFFF_FFF0);
      send_poll(8'hFF, 32'hFFFF_FFF1);
      send_poll(8'h55, 32'hFFFF_FFFF);
      send_poll(8'hAA, 32'hFFFF_FFFF);
      send_poll(8'hFF, 0);
      drain_results();
      write_reg(REG_ACTIVE_HIGH, CSR_WIDTH'(1));
      write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(15));
      write_reg(REG_DEBOUNCE_MS, CSR_WIDTH'(0));
      write_reg(REG_LONG_PRESS_MS, CSR_WIDTH'(0));
      send_poll(8'h80, 100);
      send_poll(8'h00, 101);
      send_poll(8'hFF, 102);
      send_poll(8'h00, 103);
      drain_results();
      write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(0));
      send_poll(8'hFF, 200);
      send_poll(8'h00, 201);
      drain_results();
      write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(3));
      write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
      write_reg(REG_LONG_PRESS_MS, 16'hFFFF);
      send_poll(8'h07, 1000);
      // settings change while the episode is still open
      drain_results();
      write_reg(REG_BUTTON_COUNT, CSR_WIDTH'(8));
      send_poll(8'h00, 70000);
      send_poll(8'h00, 200000);
      poll_time = 200000;

      while (polls_sent < POLL_TARGET) begin
         drain_results();
         if ($urandom_range(0, 2) != 0) pick_config();
         repeat ($urandom_range(4, 20)) begin
            case ($urandom_range(0, 9))
               0: begin
                  poll_time = $urandom;
                  send_poll(PIN_COUNT'($urandom), poll_time);
               end
               1: begin
                  poll_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                  run_episode();
               end
               default: run_episode();
            endcase
         end
      end

      drain_results();
      if (mismatches == 0 && pending == 0)
         $display("button_combo_debouncer_unit: match");
      else
         $display("button_combo_debouncer_unit: mismatch");
      $finish;
   end

endmodule
